// ===== rtl/core/tabx_pkg.sv =====
// Shared types and constants for the tab expander.
package tabx_pkg;

  localparam int unsigned CHAR_W = 16;
  localparam int unsigned TW_W   = 7;
  localparam int unsigned COL_W  = 6;

  localparam logic [TW_W-1:0]   MAX_TAB_WIDTH = 7'd64;
  localparam logic [TW_W-1:0]   TW_RESET      = 7'd8;
  localparam logic [TW_W-1:0]   TW_MIN_EXPAND = 7'd2;
  localparam logic [CHAR_W-1:0] TAB_CODE      = 16'd9;
  localparam logic [CHAR_W-1:0] SPACE_CODE    = 16'd32;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } tabx_state_e;

  typedef struct packed {
    logic accept;
    logic reduce;
    logic emit;
  } tabx_cmd_t;

  typedef struct packed {
    logic col_ge_w;
    logic beat_last;
    logic slot_free;
  } tabx_stat_t;

endpackage

// ===== rtl/core/tabx_ctrl.sv =====
// Controller state machine for the tab expander.
module tabx_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  tabx_pkg::tabx_stat_t stat_i,
  output tabx_pkg::tabx_cmd_t  cmd_o,
  output logic              in_ready_o
);
  import tabx_pkg::*;

  tabx_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!stat_i.col_ge_w && stat_i.slot_free && stat_i.beat_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_EMIT: begin
        cmd_o.reduce = stat_i.col_ge_w;
        cmd_o.emit   = !stat_i.col_ge_w && stat_i.slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/tabx_dp.sv =====
// Datapath for the tab expander: width register, column state, output register.
module tabx_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [tabx_pkg::TW_W-1:0]     cfg_tab_width_i,
  input  logic [tabx_pkg::CHAR_W-1:0]   in_char_i,
  input  logic                          line_end_i,
  input  logic                          out_ready_i,
  input  tabx_pkg::tabx_cmd_t           cmd_i,
  output tabx_pkg::tabx_stat_t          stat_o,
  output logic                          out_valid_o,
  output logic [tabx_pkg::CHAR_W-1:0]   out_char_o,
  output logic                          last_of_run_o,
  output logic                          line_done_o,
  output logic                          line_had_tab_o
);
  import tabx_pkg::*;

  logic [TW_W-1:0]   tab_width_q;
  logic [COL_W-1:0]  col_q, col_d;
  logic              seen_q, seen_d;
  logic [CHAR_W-1:0] char_q;
  logic              eol_q;
  logic              out_valid_q;
  logic [CHAR_W-1:0] out_char_q;
  logic              out_last_q;
  logic              out_done_q;
  logic              out_tab_q;

  logic [TW_W-1:0]   w_eff;
  logic [TW_W-1:0]   col_ext;
  logic [TW_W-1:0]   col_inc;
  logic [TW_W-1:0]   col_sub;
  logic              narrow;
  logic              is_tab;
  logic              wrap;
  logic              beat_last;
  logic [CHAR_W-1:0] beat_char;

  assign w_eff     = (tab_width_q > MAX_TAB_WIDTH) ? MAX_TAB_WIDTH : tab_width_q;
  assign narrow    = w_eff < TW_MIN_EXPAND;
  assign col_ext   = {1'b0, col_q};
  assign col_inc   = col_ext + 7'd1;
  assign col_sub   = col_ext - w_eff;
  assign is_tab    = char_q == TAB_CODE;
  assign wrap      = col_inc >= w_eff;
  assign beat_last = !is_tab || narrow || wrap;
  assign beat_char = is_tab ? (narrow ? SPACE_CODE : TAB_CODE) : char_q;

  assign stat_o.col_ge_w  = !narrow && (col_ext >= w_eff);
  assign stat_o.beat_last = beat_last;
  assign stat_o.slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    col_d  = col_q;
    seen_d = seen_q;
    if (cmd_i.accept) begin
      seen_d = seen_q | (in_char_i == TAB_CODE);
    end else if (cmd_i.reduce) begin
      col_d = col_sub[COL_W-1:0];
    end else if (cmd_i.emit) begin
      if (narrow || wrap) begin
        col_d = '0;
      end else begin
        col_d = col_inc[COL_W-1:0];
      end
      if (beat_last && eol_q) begin
        col_d  = '0;
        seen_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_width_q <= TW_RESET;
      col_q       <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        tab_width_q <= cfg_tab_width_i;
      end
      col_q  <= col_d;
      seen_q <= seen_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      char_q <= in_char_i;
      eol_q  <= line_end_i;
    end
    if (cmd_i.emit) begin
      out_char_q <= beat_char;
      out_last_q <= beat_last;
      out_done_q <= beat_last && eol_q;
      out_tab_q  <= seen_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_char_o     = out_char_q;
  assign last_of_run_o  = out_last_q;
  assign line_done_o    = out_done_q;
  assign line_had_tab_o = out_tab_q;

endmodule

// ===== rtl/core/tab_expander.sv =====
// Top level of the tab expander: controller plus datapath.
//
//   channel | direction | beat carries
//   cfg     | in        | cfg_tab_width_i
//   in      | in        | in_char_i, line_end_i
//   out     | out       | out_char_o, last_of_run_o, line_done_o, line_had_tab_o
//
// An ordinary character or a narrow-width tab is accepted in the idle state and
// loaded into the output register in the emit state. A tab becomes a run of
// beats, run being the distance to the next stop (1 to 64). After a width change
// mid-line the column is reduced by one subtraction per cycle until it is below
// the width. Reset clears the column, the tab flag and the output valid; the width
// returns to 8. A stalled output holds the controller in its emit state.
module tab_expander (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [tabx_pkg::TW_W-1:0]   cfg_tab_width_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tabx_pkg::CHAR_W-1:0] in_char_i,
  input  logic                        line_end_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tabx_pkg::CHAR_W-1:0] out_char_o,
  output logic                        last_of_run_o,
  output logic                        line_done_o,
  output logic                        line_had_tab_o
);
  import tabx_pkg::*;

  tabx_cmd_t  cmd;
  tabx_stat_t stat;

  assign cfg_ready_o = 1'b1;

  tabx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o)
  );

  tabx_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_tab_width_i (cfg_tab_width_i),
    .in_char_i       (in_char_i),
    .line_end_i      (line_end_i),
    .out_ready_i     (out_ready_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_char_o      (out_char_o),
    .last_of_run_o   (last_of_run_o),
    .line_done_o     (line_done_o),
    .line_had_tab_o  (line_had_tab_o)
  );

endmodule

// ===== rtl/core/tabx_checker.sv =====
// Port-level assertions for the tab expander, bound to the top level.
module tabx_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [tabx_pkg::CHAR_W-1:0] out_char_i,
  input logic                        last_of_run_i,
  input logic                        line_done_i
);
  import tabx_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_char_i)
      && $stable(last_of_run_i) && $stable(line_done_i))
    else $error("output beat changed while stalled");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && line_done_i |-> last_of_run_i)
    else $error("line end on a beat that is not last of its run");

  a_run_is_tab: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_of_run_i |-> out_char_i == TAB_CODE)
    else $error("multi-beat run carries a non-tab code");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after an accepted beat");

endmodule

bind tab_expander tabx_checker u_tabx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_i    (in_ready_o),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .out_char_i    (out_char_o),
  .last_of_run_i (last_of_run_o),
  .line_done_i   (line_done_o)
);

// ===== sim/tab_checker.sv =====
// Scoreboard for the tab expander: predicts every output beat and compares it.
module tab_checker
  import tabx_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [TW_W-1:0]   cfg_tab_width_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [CHAR_W-1:0] in_char_i,
  input  logic              line_end_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [CHAR_W-1:0] out_char_i,
  input  logic              last_of_run_i,
  input  logic              line_done_i,
  input  logic              line_had_tab_i,
  output int                mismatches_o,
  output int                pending_o
);

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              run_end;
    logic              line_end;
    logic              had_tab;
  } glyph_t;

  glyph_t           glyph_q[$];
  logic [TW_W-1:0]  stop_width;
  logic [COL_W-1:0] column;
  logic             tab_flag;
  int               errors = 0;
  int               backlog = 0;

  assign mismatches_o = errors;
  assign pending_o    = backlog;

  task automatic report(input string what);
    $display("[%0t] ERROR %s", $time, what);
    errors++;
  endtask

  // Expand one input beat into the output beats it must produce.
  task automatic expand_beat(input logic [CHAR_W-1:0] ch, input logic eol);
    logic [TW_W-1:0] w;
    logic [TW_W-1:0] run;
    logic [TW_W-1:0] nxt;
    int              i;
    w = (stop_width > MAX_TAB_WIDTH) ? MAX_TAB_WIDTH : stop_width;
    if (ch == TAB_CODE) tab_flag = 1'b1;
    if (w < TW_MIN_EXPAND) begin
      column = '0;
      glyph_q.push_back('{code: (ch == TAB_CODE) ? SPACE_CODE : ch,
                          run_end: 1'b1, line_end: eol, had_tab: tab_flag});
    end else begin
      if ({1'b0, column} >= w) column = COL_W'({1'b0, column} % w);
      if (ch == TAB_CODE) begin
        run = w - {1'b0, column};
        for (i = 1; i <= int'(run); i++) begin
          glyph_q.push_back('{code: TAB_CODE, run_end: (i == int'(run)),
                              line_end: (i == int'(run)) && eol, had_tab: tab_flag});
        end
        column = '0;
      end else begin
        glyph_q.push_back('{code: ch, run_end: 1'b1, line_end: eol, had_tab: tab_flag});
        nxt = {1'b0, column} + 1'b1;
        column = (nxt >= w) ? '0 : nxt[COL_W-1:0];
      end
    end
    if (eol) begin
      column   = '0;
      tab_flag = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    glyph_t want;
    if (!rst_ni) begin
      stop_width = TW_RESET;
      column     = '0;
      tab_flag   = 1'b0;
      glyph_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (glyph_q.size() == 0) begin
          report($sformatf("unexpected out beat char %h", out_char_i));
        end else begin
          want = glyph_q.pop_front();
          if (out_char_i !== want.code)
            report($sformatf("out_char got %h want %h", out_char_i, want.code));
          if (last_of_run_i !== want.run_end)
            report($sformatf("last_of_run got %b want %b", last_of_run_i, want.run_end));
          if (line_done_i !== want.line_end)
            report($sformatf("line_done got %b want %b", line_done_i, want.line_end));
          if (line_had_tab_i !== want.had_tab)
            report($sformatf("line_had_tab got %b want %b", line_had_tab_i, want.had_tab));
        end
      end
      if (cfg_valid_i && cfg_ready_i) stop_width = cfg_tab_width_i;
      if (in_valid_i && in_ready_i) expand_beat(in_char_i, line_end_i);
    end
    backlog = glyph_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the tab expander: clock, reset, stimulus and verdict.
module tb_top;
  import tabx_pkg::*;

  localparam int ITEMS     = 470;
  localparam int CALM_FROM = 420;
  localparam int LIMIT     = 1000000;

  logic              clk_i = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [TW_W-1:0]   cfg_width = '0;
  logic              in_valid = 1'b0;
  logic [CHAR_W-1:0] in_char = '0;
  logic              in_eol = 1'b0;
  logic              out_ready = 1'b1;
  logic              cfg_ready, in_ready, out_valid;
  logic [CHAR_W-1:0] out_char;
  logic              last_of_run, line_done, line_had_tab;
  bit                no_idle = 1'b0;
  int                sent = 0;
  int                hold = 0;
  int                cycles = 0;
  int                mismatches, pending;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  tab_expander DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_tab_width_i(cfg_width),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .in_char_i      (in_char),
    .line_end_i     (in_eol),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_char_o     (out_char),
    .last_of_run_o  (last_of_run),
    .line_done_o    (line_done),
    .line_had_tab_o (line_had_tab)
  );

  tab_checker u_tab_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_tab_width_i(cfg_width),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_char_i      (in_char),
    .line_end_i     (in_eol),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_char_i     (out_char),
    .last_of_run_i  (last_of_run),
    .line_done_i    (line_done),
    .line_had_tab_i (line_had_tab),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Stall the output side in short bursts.
  always @(posedge clk_i) begin
    if (hold != 0) begin
      hold      <= hold - 1;
      out_ready <= (hold == 1);
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      hold      <= $urandom_range(1, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic eol);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_char  <= ch;
    in_eol   <= eol;
    @(negedge clk_i);
    while (!in_ready) @(negedge clk_i);
    @(posedge clk_i);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_width(input logic [TW_W-1:0] w);
    drain();
    cfg_valid <= 1'b1;
    cfg_width <= w;
    @(negedge clk_i);
    while (!cfg_ready) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                n;
    int                kind;
    int                r;
    logic [CHAR_W-1:0] ch;
    logic              eol;
    logic [TW_W-1:0]   w;

    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // reset width of 8
    send_char(16'h0041, 1'b0);
    send_char(TAB_CODE, 1'b0);
    send_char(16'h0000, 1'b0);
    send_char(16'hFFFF, 1'b0);
    send_char(TAB_CODE, 1'b1);
    send_char(TAB_CODE, 1'b0);
    send_char(16'h0078, 1'b0);
    send_char(16'h0079, 1'b0);
    send_char(16'h007A, 1'b0);
    send_char(16'h0077, 1'b0);
    send_char(16'h0076, 1'b0);
    // narrow the stops mid-line, then try widths 0, 1, 2, 64, 127 and 65
    write_width(7'd3);
    send_char(TAB_CODE, 1'b1);
    write_width(7'd0);
    send_char(TAB_CODE, 1'b0);
    send_char(SPACE_CODE, 1'b1);
    write_width(7'd1);
    send_char(TAB_CODE, 1'b0);
    send_char(TAB_CODE, 1'b1);
    write_width(7'd2);
    send_char(TAB_CODE, 1'b0);
    send_char(16'h0061, 1'b0);
    send_char(TAB_CODE, 1'b1);
    write_width(MAX_TAB_WIDTH);
    send_char(TAB_CODE, 1'b0);
    send_char(16'h0062, 1'b1);
    write_width(7'd127);
    send_char(TAB_CODE, 1'b1);
    write_width(7'd65);
    send_char(16'h0063, 1'b0);
    send_char(TAB_CODE, 1'b1);

    while (sent < ITEMS) begin
      r = $urandom_range(0, 9);
      if (r == 0) w = TW_W'($urandom_range(0, 1));
      else if (r == 1) w = MAX_TAB_WIDTH;
      else if (r == 2) w = TW_W'($urandom_range(65, 127));
      else if (r == 3) w = TW_W'($urandom_range(13, 63));
      else w = TW_W'($urandom_range(2, 12));
      write_width(w);
      no_idle <= (sent >= CALM_FROM) || ($urandom_range(0, 3) == 0);
      n = $urandom_range(8, 40);
      repeat (n) begin
        kind = $urandom_range(0, 19);
        eol  = ($urandom_range(0, 9) == 0);
        if (kind < 5) ch = TAB_CODE;
        else if (kind == 5) ch = '0;
        else if (kind == 6) ch = '1;
        else if (kind == 7) ch = SPACE_CODE;
        else ch = CHAR_W'($urandom_range(0, 16'hFFFF));
        send_char(ch, eol);
      end
    end

    drain();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tabx_pkg.sv
rtl/core/tabx_ctrl.sv
rtl/core/tabx_dp.sv
rtl/core/tab_expander.sv
rtl/core/tabx_checker.sv
sim/tab_checker.sv
sim/tb_top.sv
